// ===== hdl/rha_pkg.sv =====
// Shared types and constants for the reference-counted handle allocator.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package rha_pkg;

  localparam int MAX_HANDLES = 1024;

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_ALLOC  = 3'd1;
  localparam logic [2:0] CMD_FREE   = 3'd2;
  localparam logic [2:0] CMD_INCR   = 3'd3;
  localparam logic [2:0] CMD_DECR   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FREED   = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  handle;
    logic [31:0] resource_id;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  handle_out;
    logic [31:0] resource_out;
    logic [15:0] ref_count;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [31:0] res;
    logic [9:0]  hdl;
    logic [15:0] refs;
  } dense_ent_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic rd_map;
    logic rd_dent;
    logic save_ent;
    logic rd_last;
    logic commit;
    logic srch;
    logic alloc_wr;
    logic fail;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_alloc;
    logic full;
    logic hit;
    logic found;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/refcounted_handle_allocator_unit.sv =====
// Top level of the reference-counted handle allocator.
// Depends on rha_pkg, rha_ctrl and rha_dp.
//
// Usage:
//   in_valid / in_stall / in_word carry request words (command, handle,
//   resource_id); out_valid / out_stall / out_word carry one result word per
//   request. A word moves on a rising edge with valid high and stall low.
//   cfg_we / cfg_wdata set the capacity; write only while the block is idle.
//   0 acts as 1, values above 1024 act as 1024.
// Operation:
//   One request at a time. Lookup, free, increment and decrement step
//   through map read, dense read, last entry read, write-back and output
//   load. Allocate reads the map, scans 32-handle windows with the next-fit
//   search (at most ceil(capacity/32)+1 windows), writes the new entry and
//   loads the output. A bad handle fails after the map read and a full
//   table at the map read. The controller returns to idle as the output
//   register is loaded, and only then accepts the next request.
//   The output register holds a finished word while the next request is
//   accepted; when out_stall stays high the controller holds in its final
//   state, keeps in_stall high and drops nothing.
// Reset:
//   Synchronous, active low. Clears the used bitmap, live count and output
//   valid; capacity returns to 1024 and the search restarts at handle 0.
`default_nettype none

module refcounted_handle_allocator_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [10:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rha_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rha_pkg::out_word_t      out_word
);

  rha_pkg::ctrl_cmd_t cmd;
  rha_pkg::dp_sts_t   sts;

  // Sequence each request through the datapath.
  rha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold tables, bitmap, search window and result word.
  rha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== hdl/rha_ctrl.sv =====
// Sequencing state machine of the handle allocator.
// Depends on rha_pkg for command and status structs.
`default_nettype none

module rha_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire rha_pkg::dp_sts_t sts,
  output rha_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MAP  = 9'b000000010,
    S_DENT = 9'b000000100,
    S_LAST = 9'b000001000,
    S_WR   = 9'b000010000,
    S_SRCH = 9'b000100000,
    S_AWR  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_FAIL = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        cmd.rd_map = 1'b1;
        if (sts.is_alloc) begin
          state_nxt = sts.full ? S_FAIL : S_SRCH;
        end else begin
          state_nxt = S_DENT;
        end
      end
      S_DENT: begin
        if (sts.hit) begin
          cmd.rd_dent = 1'b1;
          state_nxt   = S_LAST;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_LAST: begin
        cmd.save_ent = 1'b1;
        cmd.rd_last  = 1'b1;
        state_nxt    = S_WR;
      end
      S_WR: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (sts.found) state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FAIL: begin
        cmd.fail  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rha_dp.sv =====
// Datapath of the handle allocator: sparse map and dense memories, used bitmap,
// next-fit search window and result register. Depends on rha_pkg.
`default_nettype none

module rha_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [10:0]        cfg_wdata,
  input  wire rha_pkg::in_word_t  in_word,
  input  wire rha_pkg::ctrl_cmd_t cmd,
  output rha_pkg::dp_sts_t        sts,
  output rha_pkg::out_word_t      out_word
);

  localparam logic [10:0] CAP_MAX = 11'(rha_pkg::MAX_HANDLES);

  logic [10:0]         cap_r;
  logic [10:0]         cap_eff;
  logic [10:0]         live_r;
  logic [9:0]          lg_r;
  logic [rha_pkg::MAX_HANDLES-1:0] used_r;
  rha_pkg::in_word_t   in_r;
  rha_pkg::dense_ent_t ent_r;
  rha_pkg::out_word_t  res_r, res_nxt;
  logic                res_we;

  logic [9:0]          map_mem [rha_pkg::MAX_HANDLES];
  logic [9:0]          map_q;
  rha_pkg::dense_ent_t dense_mem [rha_pkg::MAX_HANDLES];
  rha_pkg::dense_ent_t dense_q;

  logic [4:0]  chk_r;
  logic        first_r;
  logic [4:0]  sofs_r;
  logic [9:0]  cur_r;
  logic [31:0] fr;
  logic [4:0]  enc;
  logic        found;
  logic [10:0] lg_p1;
  logic [9:0]  start;
  logic [10:0] cap_m1;
  logic [4:0]  lastchk;
  logic [9:0]  last_d;

  logic        map_we, dense_we, rel;
  logic [9:0]  map_wa, map_wd, dense_wa, dense_ra;
  rha_pkg::dense_ent_t dense_wd;
  logic [15:0] n_cnt;

  always_comb begin
    if (cap_r == 11'd0) begin
      cap_eff = 11'd1;
    end else if (cap_r > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_r;
    end
  end

  assign lg_p1   = {1'b0, lg_r} + 11'd1;
  assign start   = (lg_p1 >= cap_eff) ? 10'd0 : lg_p1[9:0];
  assign cap_m1  = cap_eff - 11'd1;
  assign lastchk = cap_m1[9:5];
  assign last_d  = 10'(live_r - 11'd1);

  // Free slots of the current 32-handle window.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      fr[i] = !used_r[{chk_r, 5'(i)}] && ({1'b0, chk_r, 5'(i)} < cap_eff) &&
              (!first_r || (5'(i) >= sofs_r));
    end
    enc = '0;
    for (int i = 31; i >= 0; i--) begin
      if (fr[i]) enc = 5'(i);
    end
  end
  assign found = |fr;

  assign sts.is_alloc = (in_r.command == rha_pkg::CMD_ALLOC);
  assign sts.full     = (live_r >= cap_eff);
  assign sts.hit      = ({1'b0, in_r.handle} < cap_eff) && used_r[in_r.handle] &&
                        ({1'b0, map_q} < live_r);
  assign sts.found    = found;

  assign dense_ra = cmd.rd_last ? last_d : map_q;

  // Write-back of the current command.
  always_comb begin
    map_we   = 1'b0;
    map_wa   = cur_r;
    map_wd   = live_r[9:0];
    dense_we = 1'b0;
    dense_wa = map_q;
    dense_wd = ent_r;
    rel      = 1'b0;
    res_we   = 1'b0;
    n_cnt    = '0;
    res_nxt  = '{handle_out: in_r.handle, resource_out: ent_r.res,
                 ref_count: ent_r.refs, status: rha_pkg::ST_OK};
    if (cmd.fail) begin
      res_we               = 1'b1;
      res_nxt.resource_out = '0;
      res_nxt.ref_count    = '0;
      res_nxt.status       = sts.is_alloc ? rha_pkg::ST_FULL : rha_pkg::ST_INVALID;
    end else if (cmd.alloc_wr) begin
      res_we   = 1'b1;
      map_we   = 1'b1;
      dense_we = 1'b1;
      dense_wa = live_r[9:0];
      dense_wd = '{res: in_r.resource_id, hdl: cur_r, refs: 16'd1};
      res_nxt  = '{handle_out: cur_r, resource_out: in_r.resource_id,
                   ref_count: 16'd1, status: rha_pkg::ST_OK};
    end else if (cmd.commit) begin
      res_we = 1'b1;
      case (in_r.command)
        rha_pkg::CMD_FREE: begin
          rel               = 1'b1;
          res_nxt.ref_count = '0;
        end
        rha_pkg::CMD_INCR: begin
          n_cnt             = (ent_r.refs == 16'hFFFF) ? ent_r.refs : ent_r.refs + 16'd1;
          dense_we          = 1'b1;
          dense_wd.refs     = n_cnt;
          res_nxt.ref_count = n_cnt;
        end
        rha_pkg::CMD_DECR: begin
          n_cnt = (ent_r.refs == 16'd0) ? 16'd0 : ent_r.refs - 16'd1;
          if (n_cnt == 16'd0) begin
            rel            = 1'b1;
            res_nxt.status = rha_pkg::ST_FREED;
          end else begin
            dense_we      = 1'b1;
            dense_wd.refs = n_cnt;
          end
          res_nxt.ref_count = n_cnt;
        end
        default: ;
      endcase
      // Fill the gap with the last dense entry and repoint its handle.
      if (rel && (map_q != last_d)) begin
        dense_we = 1'b1;
        dense_wd = dense_q;
        map_we   = 1'b1;
        map_wa   = dense_q.hdl;
        map_wd   = map_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd.rd_map) map_q <= map_mem[in_r.handle];
    if (dense_we) dense_mem[dense_wa] <= dense_wd;
    if (cmd.rd_dent || cmd.rd_last) dense_q <= dense_mem[dense_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) in_r <= in_word;
    if (cmd.save_ent) ent_r <= dense_q;
    if (res_we) res_r <= res_nxt;
    if (cmd.load_out) out_word <= res_r;
    if (cmd.rd_map) begin
      chk_r   <= start[9:5];
      sofs_r  <= start[4:0];
      first_r <= 1'b1;
    end else if (cmd.srch) begin
      if (found) begin
        cur_r <= {chk_r, enc};
      end else begin
        chk_r   <= (chk_r == lastchk) ? 5'd0 : chk_r + 5'd1;
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_MAX;
      live_r <= '0;
      lg_r   <= 10'(rha_pkg::MAX_HANDLES - 1);
      used_r <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.alloc_wr) begin
        used_r[cur_r] <= 1'b1;
        live_r        <= live_r + 11'd1;
        lg_r          <= cur_r;
      end else if (rel) begin
        used_r[in_r.handle] <= 1'b0;
        live_r              <= live_r - 11'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/refcounted_handle_allocator_unit_tb.sv =====
// Testbench for the reference-counted handle allocator: drives request words,
// predicts every result with a behavioral handle table and checks the whole word.
// Depends on rha_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module refcounted_handle_allocator_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [10:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  rha_pkg::in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  rha_pkg::out_word_t  out_word;

  refcounted_handle_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Shadow of the handle table.
  logic [10:0] tbl_capacity;
  bit          map_live [rha_pkg::MAX_HANDLES];
  int unsigned map_slot [rha_pkg::MAX_HANDLES];
  logic [31:0] slot_res [rha_pkg::MAX_HANDLES];
  logic [9:0]  slot_hdl [rha_pkg::MAX_HANDLES];
  logic [15:0] slot_refs [rha_pkg::MAX_HANDLES];
  int unsigned live_cnt;
  int unsigned last_grant;

  rha_pkg::out_word_t pending_results [$];
  int          mismatches;
  int          results_seen;
  int          idle_cycles;
  bit          quiet_tail;
  logic [9:0]  granted [$];   // handles granted so far, for aiming requests

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned table_size();
    int unsigned c;
    c = tbl_capacity;
    if (c == 0) c = 1;
    if (c > rha_pkg::MAX_HANDLES) c = rha_pkg::MAX_HANDLES;
    return c;
  endfunction

  task automatic table_clear();
    for (int i = 0; i < rha_pkg::MAX_HANDLES; i++) begin
      map_live[i] = 1'b0;
      map_slot[i] = 0;
    end
    tbl_capacity = 11'd1024;
    live_cnt     = 0;
    last_grant   = table_size() - 1;
  endtask

  // Pull the last dense entry into the gap and drop the handle.
  function automatic void table_release(int unsigned h, int unsigned d);
    int unsigned last;
    last = live_cnt - 1;
    if (d != last) begin
      slot_res[d]  = slot_res[last];
      slot_hdl[d]  = slot_hdl[last];
      slot_refs[d] = slot_refs[last];
      map_slot[slot_hdl[last]] = d;
    end
    live_cnt    = last;
    map_live[h] = 1'b0;
    map_slot[h] = 0;
  endfunction

  function automatic rha_pkg::out_word_t table_apply(rha_pkg::in_word_t w);
    rha_pkg::out_word_t r;
    int unsigned cap, cur, d;
    cap = table_size();
    r.handle_out   = w.handle;
    r.resource_out = '0;
    r.ref_count    = '0;
    r.status       = rha_pkg::ST_INVALID;
    if (w.command == rha_pkg::CMD_ALLOC) begin
      r.status = rha_pkg::ST_FULL;
      if (live_cnt < cap) begin
        cur = last_grant + 1;
        if (cur >= cap) cur = 0;
        for (int i = 0; i < cap; i++) begin
          if (!map_live[cur]) begin
            d = live_cnt;
            slot_res[d]  = w.resource_id;
            slot_hdl[d]  = cur[9:0];
            slot_refs[d] = 16'd1;
            map_live[cur] = 1'b1;
            map_slot[cur] = d;
            live_cnt   = d + 1;
            last_grant = cur;
            r.handle_out   = cur[9:0];
            r.resource_out = w.resource_id;
            r.ref_count    = 16'd1;
            r.status       = rha_pkg::ST_OK;
            break;
          end
          cur++;
          if (cur >= cap) cur = 0;
        end
      end
    end else if (w.handle < cap && map_live[w.handle] && map_slot[w.handle] < live_cnt) begin
      d = map_slot[w.handle];
      r.resource_out = slot_res[d];
      r.status       = rha_pkg::ST_OK;
      if (w.command == rha_pkg::CMD_FREE) begin
        table_release(w.handle, d);
      end else if (w.command == rha_pkg::CMD_INCR) begin
        if (slot_refs[d] != 16'hFFFF) slot_refs[d]++;
        r.ref_count = slot_refs[d];
      end else if (w.command == rha_pkg::CMD_DECR) begin
        if (slot_refs[d] != 0) slot_refs[d]--;
        r.ref_count = slot_refs[d];
        if (slot_refs[d] == 0) begin
          table_release(w.handle, d);
          r.status = rha_pkg::ST_FREED;
        end
      end else begin
        r.ref_count = slot_refs[d];
      end
    end
    return r;
  endfunction

  // Random idle burst on the request side, skipped in the quiet tail.
  task automatic request_gap();
    if (!quiet_tail && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 16)) @(negedge clk);
  endtask

  // Present one word, hold it until taken, predict on acceptance.
  task automatic send_request(logic [2:0] cmd, logic [9:0] h, logic [31:0] rid);
    rha_pkg::in_word_t  w;
    rha_pkg::out_word_t r;
    request_gap();
    @(negedge clk);
    w.command     = cmd;
    w.handle      = h;
    w.resource_id = rid;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = table_apply(w);
    pending_results = {pending_results, r};
    if (r.status == rha_pkg::ST_OK && cmd == rha_pkg::CMD_ALLOC)
      granted = {granted, r.handle_out};
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for the block to drain, then let it settle before a register write.
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_capacity(logic [10:0] value);
    drain();
    cfg_wdata    <= value;
    cfg_we       <= 1'b1;
    @(negedge clk);
    cfg_we       <= 1'b0;
    tbl_capacity  = value;
  endtask

  function automatic logic [9:0] pick_handle();
    int unsigned k;
    if (granted.size() != 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, granted.size() - 1);
      return granted[k];
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  // Result checker: compare each accepted word against the oldest prediction.
  always @(posedge clk) begin
    rha_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected h=%0d r=%h c=%0d s=%0d, got h=%0d r=%h c=%0d s=%0d",
                     want.handle_out, want.resource_out, want.ref_count, want.status,
                     out_word.handle_out, out_word.resource_out, out_word.ref_count,
                     out_word.status);
        end
      end
    end
  end

  // Result-side stall bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed_basics();
    send_request(rha_pkg::CMD_LOOKUP, 10'd0, 32'h0);            // empty table
    send_request(rha_pkg::CMD_ALLOC, 10'd0, 32'hFFFF_FFFF);      // grant at handle 0
    send_request(rha_pkg::CMD_ALLOC, 10'h3FF, 32'h0000_0000);
    send_request(rha_pkg::CMD_ALLOC, 10'd5, 32'hA5A5_5A5A);
    send_request(rha_pkg::CMD_LOOKUP, 10'd1, 32'h0);
    send_request(rha_pkg::CMD_INCR, 10'd0, 32'h0);
    send_request(rha_pkg::CMD_DECR, 10'd0, 32'h0);
    send_request(rha_pkg::CMD_FREE, 10'd0, 32'h0);               // moves last entry into gap
    send_request(rha_pkg::CMD_LOOKUP, 10'd2, 32'h0);
    send_request(rha_pkg::CMD_DECR, 10'd1, 32'h0);               // freeing decrement
    send_request(rha_pkg::CMD_FREE, 10'h3FF, 32'h0);             // never granted
    send_request(3'd5, 10'd2, 32'h1234_5678);           // unknown commands act as lookup
    send_request(3'd7, 10'd2, 32'h0);
    send_request(rha_pkg::CMD_INCR, 10'd700, 32'h0);
  endtask

  task automatic test_count_run();
    logic [9:0] h;
    send_request(rha_pkg::CMD_ALLOC, 10'd0, 32'hC0DE_0001);
    h = granted[granted.size() - 1];
    repeat (20) send_request(rha_pkg::CMD_INCR, h, 32'h0);     // run the count up
    send_request(rha_pkg::CMD_DECR, h, 32'h0);
    send_request(rha_pkg::CMD_LOOKUP, h, 32'h0);
  endtask

  task automatic test_small_capacity();
    set_capacity(11'd0);                                 // acts as one handle
    send_request(rha_pkg::CMD_ALLOC, 10'd0, 32'h1);
    send_request(rha_pkg::CMD_LOOKUP, 10'd0, 32'h0);
    send_request(rha_pkg::CMD_LOOKUP, 10'd2, 32'h0);     // granted earlier, now beyond capacity
    set_capacity(11'd3);
    repeat (4) send_request(rha_pkg::CMD_ALLOC, 10'd0, $urandom);  // fills and overflows
    send_request(rha_pkg::CMD_FREE, 10'd1, 32'h0);
    send_request(rha_pkg::CMD_ALLOC, 10'd0, 32'h77);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned sel;
    logic [2:0]  cmd;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) cmd = rha_pkg::CMD_ALLOC;
      else if (sel < 50) cmd = rha_pkg::CMD_LOOKUP;
      else if (sel < 65) cmd = rha_pkg::CMD_FREE;
      else if (sel < 80) cmd = rha_pkg::CMD_INCR;
      else if (sel < 97) cmd = rha_pkg::CMD_DECR;
      else cmd = 3'($urandom_range(5, 7));
      send_request(cmd, pick_handle(), $urandom);
    end
  endtask

  task automatic test_random_sweep();
    set_capacity(11'd2047);                              // clamps to full size
    random_phase(300);
    set_capacity(11'd16);
    random_phase(300);
    set_capacity(11'd1);
    random_phase(60);
    set_capacity(11'd1024);
    random_phase(200);
    set_capacity(11'd40);
    random_phase(200);
    set_capacity(11'd1040);
    random_phase(100);
    quiet_tail = 1'b1;                                   // last stretch runs without gaps
    random_phase(150);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_word    = '0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles  = 0;
    quiet_tail   = 1'b0;
    table_clear();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_basics();
    test_count_run();
    test_small_capacity();
    test_random_sweep();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Covered lookup, allocate, free, increment, decrement, unknown codes, count");
    $display("updates and capacities 0..2047; %0d result words checked.", results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rha_pkg.sv
hdl/rha_ctrl.sv
hdl/rha_dp.sv
hdl/refcounted_handle_allocator_unit.sv
sim/refcounted_handle_allocator_unit_tb.sv
